FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: src/wed_pkg.sv
`default_nettype none
package wed_pkg;

   localparam int MAX_LEN = 1024;
   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   localparam int ROW_AW  = LEN_W;
   localparam int REF_AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int COST_W  = 4;
   localparam int DIST_W  = 16;
   localparam int SYM_W   = 2;
   localparam int TBL_W   = 64;
   localparam int PROD_W  = LEN_W + COST_W;

   localparam int Q_DEPTH = 2;
   localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CW    = $clog2(Q_DEPTH + 1);

   localparam logic [DIST_W-1:0] SAT_MAX = '1;

   localparam logic [COST_W-1:0] INSERT_COST_RST = 4'd1;
   localparam logic [COST_W-1:0] DELETE_COST_RST = 4'd1;
   localparam logic [TBL_W-1:0]  SUB_TABLE_RST   = 64'h0111_1011_1101_1110;

   // command codes on the request channel
   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_QUERY  = 2'd1;
   localparam logic [1:0] CMD_END    = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   // register indexes on the csr channel
   localparam logic [1:0] CSR_INSERT_COST = 2'd0;
   localparam logic [1:0] CSR_DELETE_COST = 2'd1;
   localparam logic [1:0] CSR_SUB_TABLE   = 2'd2;

   typedef struct packed {
      logic [1:0]       command;
      logic [SYM_W-1:0] symbol;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              overflow;
   } rsp_type;

   typedef struct packed {
      logic [COST_W-1:0] insert_cost;
      logic [COST_W-1:0] delete_cost;
      logic [TBL_W-1:0]  sub_table;
   } cfg_type;

   typedef enum logic [1:0] {
      OP_APPEND,
      OP_QUERY,
      OP_END,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [SYM_W-1:0] symbol;
   } work_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_QROW0,
      ST_QRUN,
      ST_END
   } state_type;

   // saturating add; MSB of the result flags saturation
   function automatic logic [DIST_W:0] sat_add(input logic [DIST_W-1:0] a,
                                               input logic [COST_W-1:0] b);
      logic [DIST_W:0] s;
      s = {1'b0, a} + (DIST_W + 1)'(b);
      if (s[DIST_W]) begin
         return {1'b1, SAT_MAX};
      end
      return s;
   endfunction

endpackage
`default_nettype wire

FILE: src/wed_ram.sv
`default_nettype none
module wed_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: src/wed_front.sv
`default_nettype none
module wed_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire wed_pkg::req_type  req_data,
   output logic                   q_valid,
   output wed_pkg::work_type      q_item,
   input  wire logic              q_pop
);
   import wed_pkg::*;

   work_type         slot_ff [Q_DEPTH];
   logic [Q_AW-1:0]  wptr_ff, wptr_in;
   logic [Q_AW-1:0]  rptr_ff, rptr_in;
   logic [Q_CW-1:0]  count_ff, count_in;
   work_type         item;
   logic             push;

   // decode the command into a work op
   always_comb begin
      item.symbol = req_data.symbol;
      unique case (req_data.command)
         CMD_APPEND: item.op = OP_APPEND;
         CMD_QUERY:  item.op = OP_QUERY;
         CMD_END:    item.op = OP_END;
         CMD_CLEAR:  item.op = OP_CLEAR;
         default:    item.op = OP_CLEAR;
      endcase
   end

   assign req_ready = (count_ff != Q_CW'(Q_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_item    = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == Q_AW'(Q_DEPTH - 1)) ? '0 : Q_AW'(wptr_ff + 1'b1);
      end
      if (q_pop) begin
         rptr_in = (rptr_ff == Q_AW'(Q_DEPTH - 1)) ? '0 : Q_AW'(rptr_ff + 1'b1);
      end
      priority if (push && !q_pop) begin
         count_in = Q_CW'(count_ff + 1'b1);
      end else if (q_pop && !push) begin
         count_in = Q_CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= item;
      end
   end

endmodule
`default_nettype wire

FILE: src/wed_back.sv
`default_nettype none
`include "assert_macros.svh"
module wed_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire wed_pkg::cfg_type  cfg,
   input  wire logic              q_valid,
   input  wire wed_pkg::work_type q_item,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output wed_pkg::rsp_type       rsp_data
);
   import wed_pkg::*;

   state_type          state_ff, state_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [DIST_W-1:0]  bnd_ff, bnd_in;
   logic               active_ff, active_in;
   logic               ovf_ff, ovf_in;
   logic [ROW_AW-1:0]  j_ff, j_in;
   logic [DIST_W-1:0]  left_ff, left_in;
   logic [DIST_W-1:0]  diag_ff, diag_in;
   logic [SYM_W-1:0]   sym_ff, sym_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // memories
   logic               ref_we;
   logic [REF_AW-1:0]  ref_waddr, ref_raddr;
   logic [SYM_W-1:0]   ref_rdata;
   logic               row_we;
   logic [ROW_AW-1:0]  row_waddr, row_raddr;
   logic [DIST_W-1:0]  row_wdata, row_rdata;

   // datapath terms
   logic               out_free;
   logic [DIST_W:0]    bnd_sum, here_sum, a_sum, b_sum, c_sum;
   logic [DIST_W-1:0]  old_here, cell_min;
   logic [COST_W-1:0]  sub_cost;
   logic [PROD_W-1:0]  prod;
   logic               prod_ovf;

   wed_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_ref_ram (
      .clock   (clock),
      .wr_en   (ref_we),
      .wr_addr (ref_waddr),
      .wr_data (q_item.symbol),
      .rd_addr (ref_raddr),
      .rd_data (ref_rdata)
   );

   wed_ram #(.WIDTH(DIST_W), .DEPTH(MAX_LEN + 1)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_waddr),
      .wr_data (row_wdata),
      .rd_addr (row_raddr),
      .rd_data (row_rdata)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // one DP cell: min of insertion, deletion and substitution paths
   always_comb begin
      bnd_sum  = sat_add(bnd_ff, cfg.delete_cost);
      here_sum = sat_add(diag_ff, cfg.insert_cost);
      old_here = active_ff ? row_rdata : here_sum[DIST_W-1:0];
      sub_cost = cfg.sub_table[{sym_ff, ref_rdata} * COST_W +: COST_W];
      a_sum    = sat_add(left_ff, cfg.insert_cost);
      b_sum    = sat_add(old_here, cfg.delete_cost);
      c_sum    = sat_add(diag_ff, sub_cost);
      cell_min = a_sum[DIST_W-1:0];
      if (b_sum[DIST_W-1:0] < cell_min) begin
         cell_min = b_sum[DIST_W-1:0];
      end
      if (c_sum[DIST_W-1:0] < cell_min) begin
         cell_min = c_sum[DIST_W-1:0];
      end
      prod     = PROD_W'(len_ff) * PROD_W'(cfg.insert_cost);
      prod_ovf = (32'(prod) > 32'(SAT_MAX));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && (q_item.op == OP_QUERY)) begin
               state_in = ST_QROW0;
            end else if (q_valid && (q_item.op == OP_END) && out_free) begin
               state_in = ST_END;
            end
         end
         ST_QROW0: begin
            state_in = (len_ff == '0) ? ST_IDLE : ST_QRUN;
         end
         ST_QRUN: begin
            if (j_ff == len_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_END:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and register updates
   always_comb begin
      q_pop        = 1'b0;
      ref_we       = 1'b0;
      ref_waddr    = len_ff[REF_AW-1:0];
      ref_raddr    = '0;
      row_we       = 1'b0;
      row_waddr    = j_ff;
      row_wdata    = cell_min;
      row_raddr    = '0;
      len_in       = len_ff;
      bnd_in       = bnd_ff;
      active_in    = active_ff;
      ovf_in       = ovf_ff;
      j_in         = j_ff;
      left_in      = left_ff;
      diag_in      = diag_ff;
      sym_in       = sym_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               unique case (q_item.op)
                  OP_APPEND: begin
                     q_pop = 1'b1;
                     if (!active_ff) begin
                        if (len_ff < LEN_W'(MAX_LEN)) begin
                           ref_we = 1'b1;
                           len_in = LEN_W'(len_ff + 1'b1);
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end
                  end
                  OP_QUERY: begin
                     q_pop     = 1'b1;
                     row_raddr = '0;
                     sym_in    = q_item.symbol;
                  end
                  OP_END: begin
                     q_pop     = out_free;
                     row_raddr = ROW_AW'(len_ff);
                  end
                  OP_CLEAR: begin
                     q_pop     = 1'b1;
                     len_in    = '0;
                     bnd_in    = '0;
                     active_in = 1'b0;
                     ovf_in    = 1'b0;
                  end
                  default: q_pop = 1'b0;
               endcase
            end
         end
         ST_QROW0: begin
            bnd_in    = bnd_sum[DIST_W-1:0];
            left_in   = bnd_sum[DIST_W-1:0];
            ovf_in    = ovf_ff || bnd_sum[DIST_W];
            diag_in   = active_ff ? row_rdata : '0;
            row_we    = 1'b1;
            row_waddr = '0;
            row_wdata = bnd_sum[DIST_W-1:0];
            if (len_ff == '0) begin
               active_in = 1'b1;
            end else begin
               row_raddr = ROW_AW'(1);
               ref_raddr = '0;
               j_in      = ROW_AW'(1);
            end
         end
         ST_QRUN: begin
            row_we  = 1'b1;
            left_in = cell_min;
            diag_in = old_here;
            ovf_in  = ovf_ff || a_sum[DIST_W] || b_sum[DIST_W] || c_sum[DIST_W] ||
                      (!active_ff && here_sum[DIST_W]);
            if (j_ff == len_ff) begin
               active_in = 1'b1;
            end else begin
               row_raddr = ROW_AW'(j_ff + 1'b1);
               ref_raddr = j_ff[REF_AW-1:0];
               j_in      = ROW_AW'(j_ff + 1'b1);
            end
         end
         ST_END: begin
            rsp_valid_in = 1'b1;
            if (active_ff) begin
               rsp_in.distance = row_rdata;
               rsp_in.overflow = ovf_ff;
            end else begin
               rsp_in.distance = prod_ovf ? SAT_MAX : DIST_W'(prod);
               rsp_in.overflow = ovf_ff || prod_ovf;
               ovf_in          = ovf_ff || prod_ovf;
            end
            active_in = 1'b0;
            bnd_in    = '0;
         end
         default: q_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         bnd_ff       <= '0;
         active_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         bnd_ff       <= bnd_in;
         active_ff    <= active_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff    <= j_in;
      left_ff <= left_in;
      diag_ff <= diag_in;
      sym_ff  <= sym_in;
      rsp_ff  <= rsp_in;
   end

   `ASSERT_IMPL(a_run_in_range, clock, reset, state_ff == ST_QRUN, (j_ff != '0) && (j_ff <= len_ff))
   `ASSERT_IMPL(a_end_slot_free, clock, reset, state_ff == ST_END, !rsp_valid_ff)
   `ASSERT_IMPL(a_pop_only_idle, clock, reset, q_pop, state_ff == ST_IDLE)
   `ASSERT_NEXT(a_row_done_arms, clock, reset, (state_ff == ST_QRUN) && (j_ff == len_ff), active_ff)

endmodule
`default_nettype wire

FILE: src/weighted_edit_distance_core.sv
`default_nettype none
// Weighted edit distance engine for 2-bit nucleotide strings (A=0 C=1 G=2 T=3).
// Load a reference with append items (up to 1024 symbols; more sets the sticky
// overflow flag), then stream query symbols; an end item returns the distance
// of the query against the reference and rearms for the next query, and a
// clear item drops the reference and the overflow flag. Costs for insert,
// delete and the 4x4 substitution table are to be written by the user through
// the csr port only while the engine is idle; the block does not enforce this.
// All sums saturate at 65535. A query symbol fetches row entry 0, writes the
// new entry 0 and starts the sweep, then does one row-memory read/write per
// reference symbol; an end item reads the last row entry and loads the result
// register once it is free; append and clear are done in the idle state. The
// sweep through the simple dual-port row memory sets the query throughput. A
// two-item queue between the request front end and the back end lets new items
// land while a row is in progress, and the result register lets the back end
// keep going while a distance waits. No clearing pass is needed after reset.
module weighted_edit_distance_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire wed_pkg::req_type         req_data,
   // result channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output wed_pkg::rsp_type              rsp_data,
   // csr write channel
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [1:0]               csr_index,
   input  wire logic [wed_pkg::TBL_W-1:0] csr_data
);
   import wed_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      q_valid;
   logic      q_pop;
   work_type  q_item;

   // csr writes are always accepted; csr_ready is tied high
   assign csr_ready = 1'b1;

   // cost registers; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_INSERT_COST: cfg_in.insert_cost = csr_data[COST_W-1:0];
            CSR_DELETE_COST: cfg_in.delete_cost = csr_data[COST_W-1:0];
            CSR_SUB_TABLE:   cfg_in.sub_table   = csr_data;
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.insert_cost <= INSERT_COST_RST;
         cfg_ff.delete_cost <= DELETE_COST_RST;
         cfg_ff.sub_table   <= SUB_TABLE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: take items, decode, queue
   wed_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   // back end: reference/row memories, DP sweep, result register
   wed_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

// Edit distance engine bench. Drives command items (reference load, query
// symbols, end, clear) into uut, predicts every distance item with a
// single-row DP model of its own and checks what comes back, in order.
module testbench;
   import wed_pkg::*;

   // symbol codes
   localparam logic [1:0] SYM_A = 2'd0;
   localparam logic [1:0] SYM_C = 2'd1;
   localparam logic [1:0] SYM_G = 2'd2;
   localparam logic [1:0] SYM_T = 2'd3;

   // csr index that maps to no register; the write must change nothing
   localparam logic [1:0] CSR_SPARE = 2'd3;

   localparam int unsigned DIST_CAP = 65535;
   // back end can hold two queued items plus one in flight, each up to a
   // full row sweep
   localparam int DRAIN_CYCLES = 4 * (MAX_LEN + 4);
   localparam int WATCHDOG_LIMIT = 50000;
   localparam int SAT_QUERY_LEN = 4400;   // 4400 * 15 > 65535
   localparam int RANDOM_QUOTA = 145;     // per idle phase, four phases

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic [TBL_W-1:0] csr_data = '0;

   weighted_edit_distance_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Distance predictor: own copy of costs, reference and the DP row.
   // ------------------------------------------------------------------
   logic [COST_W-1:0] cost_ins = INSERT_COST_RST;
   logic [COST_W-1:0] cost_del = DELETE_COST_RST;
   logic [TBL_W-1:0]  sub_tbl  = SUB_TABLE_RST;

   logic [1:0]  ref_mem [MAX_LEN];
   int unsigned row_mem [MAX_LEN + 1];
   int unsigned ref_len = 0;
   int unsigned bound_cost = 0;   // column 0 of the current row
   bit          in_query = 1'b0;  // row memory holds a valid row
   bit          ovf_seen = 1'b0;  // sticky until clear

   rsp_type dist_expect_q[$];

   int fail_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // Saturating add. Any clipped sum sets the sticky flag, chosen path or not.
   function automatic int unsigned clip_add(int unsigned a, int unsigned b);
      int unsigned s;
      s = a + b;
      if (s > DIST_CAP) begin
         ovf_seen = 1'b1;
         return DIST_CAP;
      end
      return s;
   endfunction

   function automatic int unsigned min_of3(int unsigned a, int unsigned b, int unsigned c);
      int unsigned m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   // One query symbol sweeps the whole row. Before the first symbol of a
   // query the old row is implied as j * insert cost, built on the fly.
   function automatic void fold_query_symbol(logic [1:0] q);
      int unsigned diag, here, left, p_ins, p_del, p_sub;
      diag = in_query ? row_mem[0] : 0;
      bound_cost = clip_add(bound_cost, cost_del);
      left = bound_cost;
      row_mem[0] = left;
      for (int j = 1; j <= int'(ref_len); j++) begin
         here = in_query ? row_mem[j] : clip_add(diag, cost_ins);
         p_ins = clip_add(left, cost_ins);
         p_del = clip_add(here, cost_del);
         p_sub = clip_add(diag, sub_tbl[4 * {q, ref_mem[j - 1]} +: 4]);
         left = min_of3(p_ins, p_del, p_sub);
         row_mem[j] = left;
         diag = here;
      end
      in_query = 1'b1;
   endfunction

   // Advance the predictor by one accepted item; returns 1 with the expected
   // distance item when the command produces one.
   function automatic bit apply_item(req_type it, output rsp_type res);
      int unsigned d;
      res = '0;
      case (it.command)
         CMD_APPEND: begin
            // appends are dropped while a query is open
            if (!in_query) begin
               if (ref_len < MAX_LEN) begin
                  ref_mem[ref_len] = it.symbol;
                  ref_len++;
               end else begin
                  ovf_seen = 1'b1;
               end
            end
         end
         CMD_QUERY: fold_query_symbol(it.symbol);
         CMD_END: begin
            if (in_query) begin
               d = row_mem[ref_len];
            end else begin
               // empty query: length times insert cost
               d = 0;
               for (int j = 0; j < int'(ref_len); j++) d = clip_add(d, cost_ins);
            end
            res.distance = d[DIST_W-1:0];
            res.overflow = ovf_seen;
            in_query = 1'b0;
            bound_cost = 0;
            return 1'b1;
         end
         default: begin
            // clear: drops reference, open query and the sticky flag
            ref_len = 0;
            in_query = 1'b0;
            bound_cost = 0;
            ovf_seen = 1'b0;
         end
      endcase
      return 1'b0;
   endfunction

   task automatic note_failure(string what, rsp_type want, rsp_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s: expected distance=%0d overflow=%0b, got distance=%0d overflow=%0b",
                  $realtime, what, want.distance, want.overflow, got.distance, got.overflow);
   endtask

   // ------------------------------------------------------------------
   // Request side. Valid rises only after an optional idle gap and stays
   // up until the item is taken.
   // ------------------------------------------------------------------
   task automatic send_item(req_type it, bit fixed, rsp_type fixed_rsp);
      int gap;
      rsp_type got;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // typed-in rows still run through the predictor to keep its state
      if (apply_item(it, got))
         dist_expect_q.push_back(fixed ? fixed_rsp : got);
   endtask

   task automatic issue(logic [1:0] command, logic [1:0] symbol);
      req_type it;
      it.command = command;
      it.symbol  = symbol;
      send_item(it, 1'b0, '0);
   endtask

   // Let the engine go idle: all results back, then time for any row sweep
   // still running on items that return nothing.
   task automatic settle();
      req_valid <= 1'b0;
      while (dist_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [TBL_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_INSERT_COST: cost_ins = value[COST_W-1:0];
         CSR_DELETE_COST: cost_del = value[COST_W-1:0];
         CSR_SUB_TABLE:   sub_tbl  = value;
         default: ;
      endcase
   endtask

   // Cost registers get junk in the upper bits; only the low nibble counts.
   task automatic configure(logic [COST_W-1:0] ins, logic [COST_W-1:0] del,
                            logic [TBL_W-1:0] tbl, bit hit_spare);
      logic [TBL_W-1:0] junk;
      junk = {$urandom, $urandom};
      write_reg(CSR_INSERT_COST, {junk[TBL_W-1:COST_W], ins});
      junk = {$urandom, $urandom};
      write_reg(CSR_DELETE_COST, {junk[TBL_W-1:COST_W], del});
      write_reg(CSR_SUB_TABLE, tbl);
      if (hit_spare) write_reg(CSR_SPARE, {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed traffic: fresh references, queries closed by an end,
   // with some noise, appends inside queries and queries cut by a clear.
   task automatic run_random(int quota);
      int sent, roll, n;
      sent = 0;
      while (sent < quota) begin
         roll = $urandom_range(99);
         if (roll < 12) begin
            issue(2'($urandom_range(3)), 2'($urandom_range(3)));
            sent++;
         end else if (roll < 27) begin
            n = ($urandom_range(19) == 0) ? $urandom_range(64, 200) : $urandom_range(0, 24);
            issue(CMD_CLEAR, 2'($urandom_range(3)));
            sent++;
            repeat (n) issue(CMD_APPEND, 2'($urandom_range(3)));
         end else begin
            n = $urandom_range(0, 16);
            repeat (n) begin
               roll = $urandom_range(99);
               if (roll < 3) begin
                  issue(CMD_APPEND, 2'($urandom_range(3)));
               end else if (roll < 5) begin
                  issue(CMD_CLEAR, 2'($urandom_range(3)));
                  sent++;
               end
               issue(CMD_QUERY, 2'($urandom_range(3)));
               sent++;
            end
            issue(CMD_END, 2'($urandom_range(3)));
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Directed table, reset costs: insert 1, delete 1, 0 on the diagonal
   // and 1 off it. Distances typed in only where obvious.
   // ------------------------------------------------------------------
   typedef struct packed {
      logic [1:0]        command;
      logic [1:0]        symbol;
      logic              fixed;
      logic [DIST_W-1:0] distance;
      logic              overflow;
   } step_type;

   localparam int N_STEPS = 24;
   step_type step_table [N_STEPS] = '{
      '{CMD_END,    SYM_A, 1'b1, 16'd0, 1'b0},   // nothing loaded yet
      '{CMD_APPEND, SYM_A, 1'b0, 16'd0, 1'b0},
      '{CMD_APPEND, SYM_C, 1'b0, 16'd0, 1'b0},
      '{CMD_APPEND, SYM_G, 1'b0, 16'd0, 1'b0},
      '{CMD_APPEND, SYM_T, 1'b0, 16'd0, 1'b0},
      '{CMD_END,    SYM_T, 1'b1, 16'd4, 1'b0},   // empty query, symbol ignored
      '{CMD_QUERY,  SYM_A, 1'b0, 16'd0, 1'b0},
      '{CMD_QUERY,  SYM_C, 1'b0, 16'd0, 1'b0},
      '{CMD_QUERY,  SYM_G, 1'b0, 16'd0, 1'b0},
      '{CMD_QUERY,  SYM_T, 1'b0, 16'd0, 1'b0},
      '{CMD_END,    SYM_C, 1'b1, 16'd0, 1'b0},   // exact match
      '{CMD_QUERY,  SYM_T, 1'b0, 16'd0, 1'b0},
      '{CMD_END,    SYM_A, 1'b0, 16'd0, 1'b0},
      '{CMD_QUERY,  SYM_G, 1'b0, 16'd0, 1'b0},
      '{CMD_APPEND, SYM_A, 1'b0, 16'd0, 1'b0},   // dropped, query open
      '{CMD_QUERY,  SYM_G, 1'b0, 16'd0, 1'b0},
      '{CMD_END,    SYM_G, 1'b0, 16'd0, 1'b0},
      '{CMD_QUERY,  SYM_C, 1'b0, 16'd0, 1'b0},
      '{CMD_CLEAR,  SYM_G, 1'b0, 16'd0, 1'b0},   // kills query, no item back
      '{CMD_END,    SYM_A, 1'b1, 16'd0, 1'b0},
      '{CMD_QUERY,  SYM_T, 1'b0, 16'd0, 1'b0},   // query on empty reference
      '{CMD_QUERY,  SYM_A, 1'b0, 16'd0, 1'b0},
      '{CMD_END,    SYM_T, 1'b1, 16'd2, 1'b0},   // two deletes
      '{CMD_CLEAR,  SYM_T, 1'b0, 16'd0, 1'b0}
   };

   // ------------------------------------------------------------------
   // Result side: random back-pressure, in-order compare.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (dist_expect_q.size() == 0) begin
            note_failure("unexpected result item", '0, rsp_data);
         end else begin
            want = dist_expect_q.pop_front();
            if (rsp_data.distance !== want.distance || rsp_data.overflow !== want.overflow)
               note_failure("result mismatch", want, rsp_data);
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: too long with no item moving on any channel ends the run.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : main_seq
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed rows at reset costs
      for (int i = 0; i < N_STEPS; i++)
         send_item({step_table[i].command, step_table[i].symbol}, step_table[i].fixed,
                   {step_table[i].distance, step_table[i].overflow});

      // Full reference: one append past capacity sets the sticky flag, a
      // later query still sweeps all 1024 columns, clear drops the flag.
      settle();
      configure(4'd15, 4'd0, '0, 1'b0);
      issue(CMD_CLEAR, SYM_A);
      repeat (MAX_LEN + 1) issue(CMD_APPEND, 2'($urandom_range(3)));
      issue(CMD_END, SYM_A);
      repeat (2) issue(CMD_QUERY, 2'($urandom_range(3)));
      issue(CMD_END, SYM_G);
      issue(CMD_APPEND, SYM_T);
      issue(CMD_CLEAR, SYM_C);
      issue(CMD_END, SYM_A);

      // Saturation: long query on a short reference with maximum costs
      // drives the row past 65535; flag must persist into the next query.
      settle();
      configure(4'd15, 4'd15, '1, 1'b0);
      issue(CMD_CLEAR, SYM_A);
      repeat (3) issue(CMD_APPEND, 2'($urandom_range(3)));
      repeat (SAT_QUERY_LEN) issue(CMD_QUERY, 2'($urandom_range(3)));
      issue(CMD_END, SYM_A);
      issue(CMD_QUERY, SYM_C);
      issue(CMD_END, SYM_A);
      issue(CMD_CLEAR, SYM_A);
      issue(CMD_END, SYM_A);

      // random phases, each with its own costs and idle pattern
      for (int p = 0; p < 4; p++) begin
         settle();
         case (p)
            0: begin
               configure(4'd0, 4'd0, '0, 1'b1);
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               configure(COST_W'($urandom_range(15)), COST_W'($urandom_range(15)),
                         {$urandom, $urandom}, 1'b0);
               send_idle_pct = 58;
               recv_stall_pct = 0;
            end
            2: begin
               configure(4'd15, 4'd15, {$urandom, $urandom}, 1'b0);
               send_idle_pct = 0;
               recv_stall_pct = 58;
            end
            default: begin
               configure(COST_W'($urandom_range(15)), COST_W'($urandom_range(15)),
                         {$urandom, $urandom}, 1'b1);
               send_idle_pct = 36;
               recv_stall_pct = 36;
            end
         endcase
         run_random(RANDOM_QUOTA);
         issue(CMD_END, 2'($urandom_range(3)));
      end

      settle();
      fail_count += dist_expect_q.size();
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
